### rtl/core/lru_key_value_cache_core_defines.svh
// Assertion macros shared by the LRU key/value cache checkers.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LKVC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkvc check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkvc check failed");

`endif

### rtl/core/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic look;    // capture key compare result
    logic update;  // commit a set: cells from the front up to the target take neighbor data
  } cell_ctl_t;

endpackage

### rtl/core/lkvc_cell.sv
// One entry of the recency-ordered row: key, value, valid and match flag.
`timescale 1ns / 1ps
module lkvc_cell import lkvc_pkg::*; #(
  parameter int IDX = 0,
  parameter int OW  = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [OW-1:0]     tgt,
  input  logic [DATA_W-1:0] key_b,
  input  logic              prev_valid,
  input  logic [DATA_W-1:0] prev_key,
  input  logic [DATA_W-1:0] prev_value,
  output logic              valid,
  output logic [DATA_W-1:0] key,
  output logic [DATA_W-1:0] value,
  output logic              match
);

  localparam logic [OW-1:0] MY_POS = OW'(IDX);

  logic              valid_r, valid_nxt;
  logic              match_r, match_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic              shift;

  // cells from the front up to the target move one place back
  assign shift = ctl.update && (MY_POS <= tgt);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    match_nxt = match_r;
    if (ctl.look) begin
      match_nxt = valid_r && (key_r == key_b);
    end
    if (shift) begin
      valid_nxt = prev_valid;
      key_nxt   = prev_key;
      value_nxt = prev_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;
  assign match = match_r;

endmodule

### rtl/core/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key/value cache.
// Usage:
//   Input channel in_valid/in_ready carries one request beat: in_mode (0 get,
//   1 set), in_key, in_value. A get yields one result beat on out_valid/
//   out_ready (out_hit, out_read_value; -1 on miss). A set yields none.
//   cfg_valid/cfg_ready writes cfg_capacity (0 acts as 1, above ENTRIES acts
//   as ENTRIES); write it only while the block is idle. cfg_ready is always 1.
// Sequence:
//   A request passes through two states: ST_LOOK for the parallel key compare
//   in every cell, ST_UPD to read out or to shift the row. A get's result is
//   registered at the end of ST_UPD. A new beat is taken in the cycle the
//   previous one finishes, so the block handles one request at a time.
// Structure:
//   Entries sit in a row of cells ordered by recency, front most recent. A set
//   shifts the cells in front of the hit (or the oldest / first free cell) one
//   place back and writes the new pair at the front.
// Reset clears all valid bits and occupancy and sets capacity to 16; nothing
// else needs clearing. If the result register is full and out_ready is low, a
// get holds in ST_UPD until the register drains.
`timescale 1ns / 1ps
module lru_key_value_cache_core import lkvc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic signed [DATA_W-1:0] in_key,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_read_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic        [CAP_W-1:0]  cfg_capacity
);

  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > CAP_W) ? OW : CAP_W;

  state_t            state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [OW-1:0]     occ_r, occ_nxt;
  logic              mode_r;
  logic [DATA_W-1:0] key_r, value_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r;
  logic [DATA_W-1:0] out_value_r;

  logic              in_take, done, out_load;
  logic [CW-1:0]     cap_eff;
  logic              full;
  logic              hit;
  logic [OW-1:0]     pos, tgt;
  logic [DATA_W-1:0] sel_value;
  cell_ctl_t         ctl;

  logic              cell_valid [ENTRIES];
  logic [DATA_W-1:0] cell_key   [ENTRIES];
  logic [DATA_W-1:0] cell_value [ENTRIES];
  logic [ENTRIES-1:0] match;

  assign cfg_ready = 1'b1;

  // effective capacity, clamped to 1..ENTRIES
  always_comb begin
    cap_eff = CW'(cap_r);
    if (cap_eff == '0) begin
      cap_eff = CW'(1);
    end
    if (cap_eff > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end
  end

  assign full = CW'(occ_r) >= cap_eff;

  // match is one-hot or empty: plain OR selects value and position
  always_comb begin
    sel_value = '0;
    pos       = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_value = sel_value | (cell_value[i] & {DATA_W{match[i]}});
      pos       = pos | (match[i] ? OW'(i) : '0);
    end
  end

  assign hit = |match;

  always_comb begin
    if (hit) begin
      tgt = pos;
    end else if (full) begin
      tgt = occ_r - OW'(1);
    end else begin
      tgt = occ_r;
    end
  end

  // FSM: next state and handshake
  always_comb begin
    state_nxt = state_r;
    done      = 1'b0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        done     = (mode_r == MODE_SET) || !out_valid_r || out_ready;
        in_ready = done;
        if (done) begin
          state_nxt = in_valid ? ST_LOOK : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_take    = in_valid && in_ready;
  assign out_load   = done && (mode_r == MODE_GET);
  assign ctl.look   = (state_r == ST_LOOK);
  assign ctl.update = done && (mode_r == MODE_SET);

  always_comb begin
    occ_nxt = occ_r;
    if (ctl.update && !hit && !full) begin
      occ_nxt = occ_r + OW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r  <= in_mode;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (out_load) begin
      out_hit_r   <= hit;
      out_value_r <= hit ? sel_value : MISS_VALUE;
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic              pv;
    logic [DATA_W-1:0] pk, pd;
    if (g == 0) begin : g_front
      assign pv = 1'b1;
      assign pk = key_r;
      assign pd = value_r;
    end else begin : g_rest
      assign pv = cell_valid[g-1];
      assign pk = cell_key[g-1];
      assign pd = cell_value[g-1];
    end
    lkvc_cell #(
      .IDX (g),
      .OW  (OW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .tgt        (tgt),
      .key_b      (key_r),
      .prev_valid (pv),
      .prev_key   (pk),
      .prev_value (pd),
      .valid      (cell_valid[g]),
      .key        (cell_key[g]),
      .value      (cell_value[g]),
      .match      (match[g])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

endmodule

### rtl/core/lkvc_checker.sv
// Port-level checks for the LRU key/value cache, bound to the top level.
`timescale 1ns / 1ps
`include "lru_key_value_cache_core_defines.svh"
module lkvc_checker import lkvc_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_mode,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_hit,
  input logic signed [DATA_W-1:0] out_read_value
);

  // a miss always reads back all ones
  `LKVC_ASSERT_NOW(a_miss_value, out_valid && !out_hit, out_read_value == MISS_VALUE)

  // a taken beat drops in_ready while its key compare runs
  `LKVC_ASSERT_NEXT(a_one_per_two, in_valid && in_ready, !in_ready)

  // a fresh result beat comes only from a taken get
  `LKVC_ASSERT_NOW(a_result_from_get, $rose(out_valid),
    $past(in_valid && in_ready && (in_mode == MODE_GET), 3))

  // stalled result beat holds
  `LKVC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_read_value) && $stable(out_hit))

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hit        (out_hit),
  .out_read_value (out_read_value)
);
